// ----- rtl/pbe_pkg.sv -----
// Shared types, constants and character functions for the packed value base64 encoder.
package pbe_pkg;

    // Width of one incoming value and the range of packed widths.
    localparam int VALUE_W         = 32;
    localparam int MAX_VALUE_BITS  = 32;
    localparam int MIN_VALUE_BITS  = 10;
    localparam int WIDTH_W         = 6;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd32;

    // Packing accumulator holds up to seven leftover bits plus one value.
    localparam int ACC_W  = VALUE_W + 7;
    localparam int FILL_W = 6;

    // Header is eight characters: the fixed prefix and two width digits.
    localparam logic [2:0]  HDR_LAST   = 3'd7;
    localparam logic [47:0] HDR_PREFIX = "set:D1";

    // One input beat.
    typedef struct packed {
        logic [VALUE_W-1:0] hash_value;
        logic               last_value;
    } pbe_in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } pbe_out_t;

    // Classified item passed from the front end to the encoder engine.
    typedef struct packed {
        logic               header;
        logic               last;
        logic [WIDTH_W-1:0] width;
        logic [VALUE_W-1:0] value;
    } pbe_entry_t;

    // Map a 6-bit group to the standard base64 alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] ch;
        priority if (sextet < 6'd26) ch = "A" + {2'b00, sextet};
        else if (sextet < 6'd52)     ch = "a" + {2'b00, sextet - 6'd26};
        else if (sextet < 6'd62)     ch = "0" + {2'b00, sextet - 6'd52};
        else if (sextet == 6'd62)    ch = "+";
        else                         ch = "/";
        return ch;
    endfunction

    // Character at a given position of the header for a width of 10 to 32.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx,
                                            input logic [WIDTH_W-1:0] w);
        logic [1:0]         tens;
        logic [WIDTH_W-1:0] ones;
        logic [7:0]         ch;
        priority if (w >= 6'd30) begin
            tens = 2'd3;
            ones = w - 6'd30;
        end
        else if (w >= 6'd20) begin
            tens = 2'd2;
            ones = w - 6'd20;
        end
        else begin
            tens = 2'd1;
            ones = w - 6'd10;
        end
        unique case (idx)
            3'd6:    ch = "0" + {6'b0, tens};
            3'd7:    ch = "0" + {2'b0, ones};
            default: ch = HDR_PREFIX[47 - 8*idx -: 8];
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/pbe_fifo.sv -----
// Small register-based queue used between the stages of the encoder.
module pbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/pbe_front.sv -----
// Front end: width register, value masking and header classification.
module pbe_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pbe_pkg::WIDTH_W-1:0]       cfg_wr_data,
    input  logic                              push,
    input  pbe_pkg::pbe_in_t                  in_data,
    input  logic                              q_full,
    output logic                              q_push,
    output pbe_pkg::pbe_entry_t               q_entry
);

    import pbe_pkg::*;

    logic [WIDTH_W-1:0] bits_per_value_reg;
    logic [WIDTH_W-1:0] used_w;
    logic [VALUE_W-1:0] value_mask;
    logic               header_pending_reg, header_pending_next;

    // Clamp the configured width to the supported range.
    always_comb
    begin
        priority if (bits_per_value_reg < WIDTH_W'(MIN_VALUE_BITS))
            used_w = WIDTH_W'(MIN_VALUE_BITS);
        else if (bits_per_value_reg > WIDTH_W'(MAX_VALUE_BITS))
            used_w = WIDTH_W'(MAX_VALUE_BITS);
        else
            used_w = bits_per_value_reg;
    end

    assign value_mask = {VALUE_W{1'b1}} >> (WIDTH_W'(VALUE_W) - used_w);

    // Build the queue entry for the accepted beat.
    assign q_push          = push && !q_full;
    assign q_entry.header  = header_pending_reg;
    assign q_entry.last    = in_data.last_value;
    assign q_entry.width   = used_w;
    assign q_entry.value   = in_data.hash_value & value_mask;

    // The header is due again after the last value of a set.
    assign header_pending_next = q_push ? in_data.last_value : header_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_per_value_reg <= WIDTH_RESET;
            header_pending_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bits_per_value_reg <= cfg_wr_data;
            end
            header_pending_reg <= header_pending_next;
        end
    end

endmodule

// ----- rtl/pbe_back.sv -----
// Encoder engine: emits header characters, packs values and slices base64 groups.
module pbe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  pbe_pkg::pbe_entry_t   q_entry,
    output logic                  q_pop,
    input  logic                  o_full,
    output logic                  o_push,
    output pbe_pkg::pbe_out_t     o_data
);

    import pbe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_HEADER = 3'b010,
        ST_DATA   = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         hdr_idx_reg, hdr_idx_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               last_reg, last_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [FILL_W-1:0]  bfill_reg, bfill_next;
    logic [5:0]         win_reg, win_next;
    logic [2:0]         wcnt_reg, wcnt_next;

    logic [ACC_W-1:0]   post_acc;
    logic [FILL_W-1:0]  post_bfill;
    logic [5:0]         post_win;
    logic [2:0]         post_wcnt;
    logic [11:0]        fed;
    logic [5:0]         feed_sextet;
    logic [5:0]         feed_win;
    logic [2:0]         feed_wcnt;
    logic [5:0]         data_sextet;
    logic               emit_data;
    logic               more;
    logic               advance;
    logic               load;

    assign advance = !o_full;

    // One byte joined to the leftover bits yields the next group.
    assign fed = {win_reg[3:0], acc_reg[7:0]};
    always_comb
    begin
        unique case (wcnt_reg)
            3'd0:
            begin
                feed_sextet = fed[7:2];
                feed_win    = {4'b0, fed[1:0]};
                feed_wcnt   = 3'd2;
            end
            3'd2:
            begin
                feed_sextet = fed[9:4];
                feed_win    = {2'b0, fed[3:0]};
                feed_wcnt   = 3'd4;
            end
            default:
            begin
                feed_sextet = fed[11:6];
                feed_win    = fed[5:0];
                feed_wcnt   = 3'd6;
            end
        endcase
    end

    // Pick the next payload group: a full leftover group, a full byte,
    // the zero-filled partial byte, or the zero-filled partial group.
    always_comb
    begin
        post_acc    = acc_reg;
        post_bfill  = bfill_reg;
        post_win    = win_reg;
        post_wcnt   = wcnt_reg;
        data_sextet = '0;
        emit_data   = 1'b1;
        priority if (wcnt_reg == 3'd6)
        begin
            data_sextet = win_reg;
            post_win    = '0;
            post_wcnt   = '0;
        end
        else if (bfill_reg >= FILL_W'(8))
        begin
            data_sextet = feed_sextet;
            post_win    = feed_win;
            post_wcnt   = feed_wcnt;
            post_acc    = acc_reg >> 8;
            post_bfill  = bfill_reg - FILL_W'(8);
        end
        else if (last_reg && bfill_reg != '0)
        begin
            data_sextet = feed_sextet;
            post_win    = feed_win;
            post_wcnt   = feed_wcnt;
            post_acc    = '0;
            post_bfill  = '0;
        end
        else if (last_reg && wcnt_reg != '0)
        begin
            data_sextet = (wcnt_reg == 3'd2) ? {win_reg[1:0], 4'b0} : {win_reg[3:0], 2'b0};
            post_win    = '0;
            post_wcnt   = '0;
        end
        else
        begin
            emit_data = 1'b0;
        end
        more = (post_wcnt == 3'd6) || (post_bfill >= FILL_W'(8))
            || (last_reg && (post_bfill != '0 || post_wcnt != '0));
        // A finished set leaves the packing state clear.
        if (last_reg && !more)
        begin
            post_acc   = '0;
            post_bfill = '0;
            post_win   = '0;
            post_wcnt  = '0;
        end
    end

    // Sequencer and the next entry taken as the current one finishes.
    always_comb
    begin
        state_next       = state_reg;
        hdr_idx_next     = hdr_idx_reg;
        width_next       = width_reg;
        last_next        = last_reg;
        acc_next         = acc_reg;
        bfill_next       = bfill_reg;
        win_next         = win_reg;
        wcnt_next        = wcnt_reg;
        o_push           = 1'b0;
        o_data.character = b64_char(data_sextet);
        o_data.last_char = 1'b0;
        load             = 1'b0;
        unique case (state_reg)
            ST_HEADER:
            begin
                o_data.character = hdr_char(hdr_idx_reg, width_reg);
                if (advance)
                begin
                    o_push       = 1'b1;
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == HDR_LAST)
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                o_data.last_char = last_reg && !more;
                if (advance)
                begin
                    o_push     = emit_data;
                    acc_next   = post_acc;
                    bfill_next = post_bfill;
                    win_next   = post_win;
                    wcnt_next  = post_wcnt;
                    if (!more)
                    begin
                        state_next = ST_IDLE;
                        load       = !q_empty;
                    end
                end
            end
            default:
            begin
                load = !q_empty;
            end
        endcase
        if (load)
        begin
            acc_next     = acc_next | (ACC_W'(q_entry.value) << bfill_next[2:0]);
            bfill_next   = bfill_next + q_entry.width;
            width_next   = q_entry.width;
            last_next    = q_entry.last;
            hdr_idx_next = '0;
            state_next   = q_entry.header ? ST_HEADER : ST_DATA;
        end
    end

    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hdr_idx_reg <= '0;
            acc_reg     <= '0;
            bfill_reg   <= '0;
            win_reg     <= '0;
            wcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hdr_idx_reg <= hdr_idx_next;
            acc_reg     <= acc_next;
            bfill_reg   <= bfill_next;
            win_reg     <= win_next;
            wcnt_reg    <= wcnt_next;
        end
    end

    // Entry attributes need no reset.
    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        last_reg  <= last_next;
    end

    // During the header the accumulator holds only the new value.
    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HEADER |-> wcnt_reg == '0 && bfill_reg == width_reg)
        else $error("header started with leftover packing bits");

    // After the final beat of a set with no new entry, the engine is clear and idle.
    a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
        o_push && o_data.last_char && !load |=>
            state_reg == ST_IDLE && bfill_reg == '0 && wcnt_reg == '0)
        else $error("packing state left over after end of set");

    // An idle engine never holds a complete byte or group.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> bfill_reg < FILL_W'(8) && wcnt_reg < 3'd6)
        else $error("engine went idle with output still owed");

    // Leftover group bits always come in pairs.
    a_wcnt_even: assert property (@(posedge clk) disable iff (!rst_n)
        !wcnt_reg[0] && wcnt_reg <= 3'd6)
        else $error("group fill count out of step");

endmodule

// ----- rtl/packed_value_base64_encoder.sv -----
// Top level of the packed value base64 encoder: front end, entry queue, engine, output queue.
//
//  Channel   Handshake               Payload
//  input     push / full             in_data  (hash_value, last_value)
//  result    empty / pop             out_data (character, last_char)
//  config    cfg_wr_en               cfg_wr_data (bits_per_value)
//
// The engine issues one character per cycle while the output queue has room;
// an item of width w gives about w/6 characters, a new set first gives the header,
// and the last item of a set flushes its leftover bits as zero-filled characters.
// Items enter back to back through a two-entry queue; results leave through a
// two-entry queue, so a stalled pop holds the engine while inputs still queue.
// After reset the width is 32 and the header is due on the first item.
module packed_value_base64_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pbe_pkg::WIDTH_W-1:0]   cfg_wr_data,
    input  logic                          push,
    input  pbe_pkg::pbe_in_t              in_data,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output pbe_pkg::pbe_out_t             out_data
);

    import pbe_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    pbe_entry_t q_wr_entry;
    pbe_entry_t q_rd_entry;
    logic       o_push;
    logic       o_full;
    pbe_out_t   o_data;

    // Masking, width clamp and header tracking.
    pbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .in_data     (in_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_wr_entry)
    );

    assign full = q_full;

    // Entries waiting for the engine.
    pbe_fifo #(
        .WIDTH ($bits(pbe_entry_t)),
        .DEPTH (2)
    ) u_entry_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_entry),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_entry),
        .empty   (q_empty)
    );

    // Character engine.
    pbe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_rd_entry),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_data  (o_data)
    );

    // Result beats waiting to be popped.
    pbe_fifo #(
        .WIDTH ($bits(pbe_out_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (o_push),
        .wr_data (o_data),
        .full    (o_full),
        .pop     (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

endmodule
